@@ rtl/ils_pkg.sv @@
// ils_pkg: operation and status codes and the per-cell control bundle
// shared by the list store cells and the list store top level
// no dependencies
`default_nettype none

package ils_pkg;

  // index width carried to the cells, enough for a capacity of 256
  localparam int unsigned CtrlIdxBits = 9;

  // operation codes on kind_i
  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_GET    = 3'd1,
    KIND_SET    = 3'd2,
    KIND_POP    = 3'd3,
    KIND_FIND   = 3'd4
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic                   write;   // load word into the cell at target
    logic                   pop;     // cells from target up to fill-2 take their right neighbor
    logic [CtrlIdxBits-1:0] target;  // entry index the operation works on
    logic [CtrlIdxBits-1:0] fill;    // number of live entries before the operation
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/indexed_list_store_unit.sv @@
// indexed_list_store_unit: fixed-capacity ordered list of words built as a
// row of entry cells; append, get, set, pop with gap closing, and find
// depends on ils_pkg and ils_cell
// the result is registered at the edge that accepts the item
// throughput: 1 item per cycle; input stalls only while a result waits on a stalled output
// every operation acts on the whole cell row in parallel (shift on pop, compare on find)
// reset: fill count and output valid clear; entry contents are left as they are
`default_nettype none

module indexed_list_store_unit
  import ils_pkg::*;
#(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // operation channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        kind_i,
  input  wire logic signed [5:0] position_i,
  input  wire logic [31:0]       word_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             status_o,
  output logic [31:0]            read_word_o,
  output logic signed [4:0]      found_at_o,
  output logic [4:0]             count_o
);

  localparam int unsigned EntryBits = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int unsigned IdxBits   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FillBits  = $clog2(CAPACITY + 1);
  localparam int unsigned PosBits   = ((FillBits > 6) ? FillBits : 6) + 2;
  localparam logic [FillBits-1:0] FillMax = FillBits'(CAPACITY);

  logic                 in_xfer;
  logic                 out_valid_q;
  logic [FillBits-1:0]  fill_q;
  logic [FillBits-1:0]  fill_d;
  logic [1:0]           status_q;
  logic [1:0]           status_d;
  logic [31:0]          read_word_q;
  logic [31:0]          read_word_d;
  logic [4:0]           found_at_q;
  logic [4:0]           found_at_d;

  logic [EntryBits-1:0] word_cut;
  logic signed [PosBits-1:0] pos_abs;
  logic                 pos_ok;
  logic [IdxBits-1:0]   slot;
  cell_ctrl_t           ctrl;

  logic [EntryBits-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]  hits;
  logic [CAPACITY-1:0]  first_hit;
  logic [IdxBits-1:0]   hit_idx;
  logic [EntryBits-1:0] slot_word;

  // input transfer and stall, and the input word cut to the entry width
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign word_cut   = EntryBits'(word_i);

  // resolve a signed position against the fill count
  always_comb begin
    pos_abs = PosBits'(position_i);
    if (position_i < 0) begin
      pos_abs = pos_abs + PosBits'($signed({1'b0, fill_q}));
    end
    pos_ok = (pos_abs >= 0) && (pos_abs < PosBits'($signed({1'b0, fill_q})));
    slot   = pos_abs[IdxBits-1:0];
  end

  // read the resolved slot out of the row
  always_comb begin
    slot_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_word = slot_word | ({EntryBits{slot == IdxBits'(i)}} & entries[i]);
    end
  end

  // lowest matching entry: isolate the lowest set hit, then encode it
  always_comb begin
    first_hit = hits & (~hits + CAPACITY'(1));
    hit_idx   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_idx = hit_idx | ({IdxBits{first_hit[i]}} & IdxBits'(i));
    end
  end

  // operation decode: cell control, next fill and the result fields
  always_comb begin
    ctrl        = '0;
    ctrl.fill   = CtrlIdxBits'(fill_q);
    ctrl.target = CtrlIdxBits'(slot);
    fill_d      = fill_q;
    status_d    = STATUS_OK;
    read_word_d = '0;
    found_at_d  = '1;
    case (kind_e'(kind_i))
      KIND_APPEND: begin
        if (fill_q == FillMax) begin
          status_d = STATUS_FULL;
        end else begin
          ctrl.write  = in_xfer;
          ctrl.target = CtrlIdxBits'(fill_q);
          fill_d      = fill_q + FillBits'(1);
        end
      end
      KIND_GET: begin
        if (pos_ok) begin
          read_word_d = 32'(slot_word);
        end else begin
          status_d = STATUS_RANGE;
        end
      end
      KIND_SET: begin
        if (pos_ok) begin
          ctrl.write = in_xfer;
        end else begin
          status_d = STATUS_RANGE;
        end
      end
      KIND_POP: begin
        if (pos_ok) begin
          read_word_d = 32'(slot_word);
          ctrl.pop    = in_xfer;
          fill_d      = fill_q - FillBits'(1);
        end else begin
          status_d = STATUS_RANGE;
        end
      end
      KIND_FIND: begin
        if (|hits) begin
          found_at_d = 5'(hit_idx);
        end
      end
      default: begin
      end
    endcase
  end

  // row of entry cells, each handing its entry to its left neighbor on pop
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [EntryBits-1:0] right_entry;
    if (g + 1 < CAPACITY) begin : g_mid
      assign right_entry = entries[g+1];
    end else begin : g_last
      assign right_entry = '0;
    end
    ils_cell #(
      .ENTRY_BITS (EntryBits),
      .INDEX      (g)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .word_i        (word_cut),
      .right_entry_i (right_entry),
      .entry_o       (entries[g]),
      .hit_o         (hits[g])
    );
  end

  // fill count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register, loaded on every input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      status_q    <= status_d;
      read_word_q <= read_word_d;
      found_at_q  <= found_at_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign read_word_o = read_word_q;
  assign found_at_o  = found_at_q;
  assign count_o     = 5'(fill_q);

  // fill count never passes capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("fill count above capacity");

  // at most one entry is reported as the first match
  a_first_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first_hit))
    else $error("more than one first match");

  // full status only when the list was full at the transfer
  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && fill_q != FillMax) |=> status_o != STATUS_FULL)
    else $error("full status with room left");

  // every input transfer presents a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("transfer without a result");

endmodule

`default_nettype wire

@@ rtl/ils_cell.sv @@
// ils_cell: one entry of the list store chain; loads a new word, takes its
// right neighbor's entry on pop, and compares its entry against the search word
// depends on ils_pkg
`default_nettype none

module ils_cell
  import ils_pkg::*;
#(
  parameter int unsigned ENTRY_BITS = 32,
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic [ENTRY_BITS-1:0] word_i,
  input  wire logic [ENTRY_BITS-1:0] right_entry_i,
  output logic      [ENTRY_BITS-1:0] entry_o,
  output logic                       hit_o
);

  localparam logic [CtrlIdxBits-1:0] MyIdx   = CtrlIdxBits'(INDEX);
  localparam logic [CtrlIdxBits-1:0] NextIdx = CtrlIdxBits'(INDEX + 1);

  logic [ENTRY_BITS-1:0] entry_q;
  logic [ENTRY_BITS-1:0] entry_d;
  logic                  live;
  logic                  do_write;
  logic                  do_shift;

  // decode this cell's share of the operation
  always_comb begin
    live     = MyIdx < ctrl_i.fill;
    do_write = ctrl_i.write && (ctrl_i.target == MyIdx);
    do_shift = ctrl_i.pop && (MyIdx >= ctrl_i.target) && (NextIdx < ctrl_i.fill);
    entry_d  = entry_q;
    if (do_write) begin
      entry_d = word_i;
    end else if (do_shift) begin
      entry_d = right_entry_i;
    end
  end

  // entry storage, no reset: only live entries are ever read
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // search compare, live entries only
  assign hit_o   = live && (entry_q == word_i);
  assign entry_o = entry_q;

endmodule

`default_nettype wire
